// File: hw/rtl/nmea_line_framer_top_macros.svh
// ----------------------------------------------------------------------------
// nmea line framer assertion macros
// concurrent checks on the rising clock edge, off while reset is low
// ----------------------------------------------------------------------------
`ifndef NMEA_LINE_FRAMER_TOP_MACROS_SVH
`define NMEA_LINE_FRAMER_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define NLF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nlf same-cycle check failed");
// next-cycle implication
`define NLF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nlf next-cycle check failed");
`else
`define NLF_ASSERT_IMP(lbl, ante, cons)
`define NLF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/nlf_pkg.sv
// ----------------------------------------------------------------------------
// nlf_pkg
// shared types and character codes of the nmea line framer
// ----------------------------------------------------------------------------
package nlf_pkg;

    typedef enum logic [1:0] {
        ACT_RX   = 2'd0,
        ACT_READ = 2'd1,
        ACT_TAKE = 2'd2
    } t_action;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // result fields known when the request is accepted
    typedef struct packed {
        logic       is_read;
        logic       ok;
        logic [6:0] copy_length;
        logic       line_waiting;
    } t_meta;

    // framer state visible to the top level
    typedef struct packed {
        logic ready_flag;
        logic in_line;
        logic overflowed;
    } t_status;

    // occupancy of the two result stages
    typedef struct packed {
        logic a_valid;
        logic b_valid;
    } t_pipe;

endpackage

// File: hw/rtl/nlf_line_ram.sv
// ----------------------------------------------------------------------------
// nlf_line_ram
// two line banks in one memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module nlf_line_ram #(
    parameter int AW = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW:0]   i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW:0]   i_raddr,
    output logic [7:0]    o_rdata
);

    localparam int Depth = 2 ** (AW + 1);

    logic [7:0] r_mem [0:Depth-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/nlf_framer.sv
// ----------------------------------------------------------------------------
// nlf_framer
// line assembly state, bank swap and request decode
// ----------------------------------------------------------------------------
module nlf_framer import nlf_pkg::*; #(
    parameter int LINE_SIZE = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic [1:0]                    i_action,
    input  logic [7:0]                    i_rx_data,
    input  logic [6:0]                    i_read_index,
    input  logic [7:0]                    i_take_size,
    output logic                          o_mem_we,
    output logic [$clog2(LINE_SIZE):0]    o_mem_waddr,
    output logic [7:0]                    o_mem_wdata,
    output logic                          o_mem_re,
    output logic [$clog2(LINE_SIZE):0]    o_mem_raddr,
    output t_meta                         o_meta,
    output t_status                       o_status
);

    localparam int LW = $clog2(LINE_SIZE);
    localparam int CW = (LW > 7) ? LW : 7;
    localparam int SW = (LW + 1 > 8) ? LW + 1 : 8;

    logic [LW-1:0] r_asm_len, n_asm_len;
    logic [LW-1:0] r_rdy_len, n_rdy_len;
    logic          r_rdy_flag, n_rdy_flag;
    logic          r_in_line, n_in_line;
    logic          r_ovf, n_ovf;
    logic          r_rdy_bank, n_rdy_bank;

    logic [CW-1:0] idx_ext;
    logic          rd_ok;
    logic [SW-1:0] size_ext;
    logic [SW-1:0] size_sat;
    logic [SW-1:0] len_s;
    logic [SW-1:0] take_n;
    logic          we;
    logic [LW-1:0] waddr_lo;
    logic          re;

    assign idx_ext  = CW'(i_read_index);
    assign rd_ok    = idx_ext < CW'(r_rdy_len);
    assign size_ext = SW'(i_take_size);
    assign size_sat = (size_ext > SW'(LINE_SIZE)) ? SW'(LINE_SIZE) : size_ext;
    assign len_s    = SW'(r_rdy_len);
    assign take_n   = (len_s >= size_sat) ? size_sat - SW'(1) : len_s;

    always_comb begin
        n_asm_len  = r_asm_len;
        n_rdy_len  = r_rdy_len;
        n_rdy_flag = r_rdy_flag;
        n_in_line  = r_in_line;
        n_ovf      = r_ovf;
        n_rdy_bank = r_rdy_bank;
        we         = 1'b0;
        waddr_lo   = r_asm_len;
        re         = 1'b0;
        o_meta.is_read     = 1'b0;
        o_meta.ok          = 1'b0;
        o_meta.copy_length = 7'(r_rdy_len);
        case (t_action'(i_action))
            ACT_RX: begin
                if (i_rx_data == CH_DOLLAR) begin
                    // dollar restarts the line at entry zero
                    n_in_line = 1'b1;
                    n_ovf     = 1'b0;
                    we        = 1'b1;
                    waddr_lo  = '0;
                    n_asm_len = LW'(1);
                end else if (r_in_line) begin
                    if (i_rx_data == CH_LF) begin
                        if (!r_ovf && r_asm_len != '0 && !r_rdy_flag) begin
                            // hand the assembled bank over to the reader
                            n_rdy_len  = r_asm_len;
                            n_rdy_flag = 1'b1;
                            n_rdy_bank = ~r_rdy_bank;
                        end
                        n_in_line = 1'b0;
                        n_ovf     = 1'b0;
                        n_asm_len = '0;
                    end else if (i_rx_data != CH_CR) begin
                        if (r_asm_len < LW'(LINE_SIZE - 1)) begin
                            we        = 1'b1;
                            n_asm_len = r_asm_len + LW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                // length as it stands after this byte
                o_meta.copy_length = 7'(n_rdy_len);
            end
            ACT_READ: begin
                re             = 1'b1;
                o_meta.is_read = 1'b1;
                o_meta.ok      = rd_ok;
            end
            ACT_TAKE: begin
                o_meta.copy_length = '0;
                if (size_sat != '0 && r_rdy_flag) begin
                    o_meta.copy_length = 7'(take_n);
                    o_meta.ok          = 1'b1;
                    n_rdy_flag         = 1'b0;
                    n_rdy_len          = '0;
                end
            end
            default: begin
            end
        endcase
        o_meta.line_waiting = n_rdy_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asm_len  <= '0;
            r_rdy_len  <= '0;
            r_rdy_flag <= 1'b0;
            r_in_line  <= 1'b0;
            r_ovf      <= 1'b0;
            r_rdy_bank <= 1'b0;
        end else if (i_acc) begin
            r_asm_len  <= n_asm_len;
            r_rdy_len  <= n_rdy_len;
            r_rdy_flag <= n_rdy_flag;
            r_in_line  <= n_in_line;
            r_ovf      <= n_ovf;
            r_rdy_bank <= n_rdy_bank;
        end
    end

    // assembly bank is always the one the reader does not own
    assign o_mem_we    = we && i_acc;
    assign o_mem_waddr = {~r_rdy_bank, waddr_lo};
    assign o_mem_wdata = i_rx_data;
    assign o_mem_re    = re && i_acc;
    assign o_mem_raddr = {r_rdy_bank, idx_ext[LW-1:0]};

    assign o_status.ready_flag = r_rdy_flag;
    assign o_status.in_line    = r_in_line;
    assign o_status.overflowed = r_ovf;

endmodule

// File: hw/rtl/nlf_out_stage.sv
// ----------------------------------------------------------------------------
// nlf_out_stage
// memory read stage followed by the output register, with skid behavior
// ----------------------------------------------------------------------------
module nlf_out_stage import nlf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  t_meta       i_meta,
    input  logic [7:0]  i_rdata,
    output logic        o_in_ready,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [23:0] o_tdata,
    output t_pipe       o_pipe
);

    logic        r_a_valid;
    t_meta       r_a_meta;
    logic        r_b_valid;
    logic [23:0] r_b_data;
    logic        adv;
    logic [7:0]  data_byte;

    assign adv        = r_a_valid && (!r_b_valid || i_tready);
    assign o_in_ready = !r_a_valid || adv;
    assign data_byte  = (r_a_meta.is_read && r_a_meta.ok) ? i_rdata : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_acc) begin
                r_a_valid <= 1'b1;
            end else if (adv) begin
                r_a_valid <= 1'b0;
            end
            if (adv) begin
                r_b_valid <= 1'b1;
            end else if (i_tready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_a_meta <= i_meta;
        end
        if (adv) begin
            r_b_data <= {7'd0, r_a_meta.line_waiting, r_a_meta.copy_length,
                         data_byte, r_a_meta.ok};
        end
    end

    assign o_tvalid       = r_b_valid;
    assign o_tdata        = r_b_data;
    assign o_pipe.a_valid = r_a_valid;
    assign o_pipe.b_valid = r_b_valid;

endmodule

// File: hw/rtl/nmea_line_framer_top.sv
// ----------------------------------------------------------------------------
// nmea_line_framer_top
// assembles dollar-started text lines from received bytes into a ready line
// ----------------------------------------------------------------------------
// usage: each request on the slave stream carries its kind in tuser: a
// received byte, a read of one ready-line byte by index, or a take of the
// ready line. every request gives exactly one result on the master stream.
// lines live in one memory holding two banks; ending a good line swaps the
// bank roles, so no copy takes place. a request enters on every cycle the
// slave side is ready; its result goes through the registered memory
// read with the read stage, then through the output register.
// throughput is one request per cycle while the receiver does not stall,
// set by the single write and single read access the memory takes per
// cycle. when the receiver stalls, one more request is accepted into the
// read stage; then tready drops until the output register drains. reset
// clears the line state and both result stages; memory is not cleared.
// ----------------------------------------------------------------------------
`include "nmea_line_framer_top_macros.svh"

module nmea_line_framer_top import nlf_pkg::*; #(
    parameter int LINE_SIZE = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: rx_data[7:0], read_index[14:8], take_size[22:15], zero [23]
    input  logic [23:0] i_s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: ok[0], data_byte[8:1], copy_length[15:9], line_waiting[16], zero [23:17]
    output logic [23:0] o_m_axis_tdata
);

    localparam int LW = $clog2(LINE_SIZE);

    logic          w_acc;
    logic          w_in_ready;
    logic          w_we;
    logic [LW:0]   w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [LW:0]   w_raddr;
    logic [7:0]    w_rdata;
    t_meta         w_meta;
    t_status       w_status;
    t_pipe         w_pipe;

    assign w_acc           = i_s_axis_tvalid && w_in_ready;
    assign o_s_axis_tready = w_in_ready;

    nlf_framer #(
        .LINE_SIZE (LINE_SIZE)
    ) u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (w_acc),
        .i_action     (i_s_axis_tuser),
        .i_rx_data    (i_s_axis_tdata[7:0]),
        .i_read_index (i_s_axis_tdata[14:8]),
        .i_take_size  (i_s_axis_tdata[22:15]),
        .o_mem_we     (w_we),
        .o_mem_waddr  (w_waddr),
        .o_mem_wdata  (w_wdata),
        .o_mem_re     (w_re),
        .o_mem_raddr  (w_raddr),
        .o_meta       (w_meta),
        .o_status     (w_status)
    );

    nlf_line_ram #(
        .AW (LW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nlf_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (w_acc),
        .i_meta     (w_meta),
        .i_rdata    (w_rdata),
        .o_in_ready (w_in_ready),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata),
        .o_pipe     (w_pipe)
    );

    // read stage only holds a request while the output register is full
    `NLF_ASSERT_NXT(a_skid_order, w_pipe.a_valid && !w_pipe.b_valid, w_pipe.b_valid)
    // overflow mark never outlives its line
    `NLF_ASSERT_IMP(a_ovf_in_line, !w_status.in_line, !w_status.overflowed)
    // a take with a line waiting and a nonzero size always frees the line
    `NLF_ASSERT_NXT(a_take_clears, w_acc && i_s_axis_tuser == ACT_TAKE && w_status.ready_flag && i_s_axis_tdata[22:15] != 8'd0, !w_status.ready_flag)

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: nmea line framer testbench
// Drives received bytes, line reads and line takes through the request
// stream. Each result is checked against a line-assembly predictor that
// runs at request acceptance, or against the result a typed directed row
// carries. A short directed table comes first, then random sentences
// (well-formed, broken and overlong) mixed with consumer reads, takes and
// noise. Both stream sides idle or stall at random, in several phases.
// ----------------------------------------------------------------------------
module tb_top;
    import nlf_pkg::*;

    localparam int          LINE_SIZE  = 128;
    localparam int          CYCLE_CAP  = 400000;
    localparam int          DRAIN_WAIT = 20;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;

    // fields from the lowest bit up: ok, data_byte, copy_length, line_waiting
    typedef struct packed {
        logic       line_waiting;
        logic [6:0] copy_length;
        logic [7:0] data_byte;
        logic       ok;
    } t_line_result;

    typedef struct packed {
        logic [1:0]   act;
        logic [7:0]   rx;
        logic [6:0]   idx;
        logic [7:0]   size;
        logic         typed;
        t_line_result want;
    } t_stim_row;

    localparam t_line_result ZERO_RES = '0;
    localparam t_line_result KEPT_RES = '{1'b1, 7'd0, 8'h00, 1'b0};

    // directed rows; typed rows carry their result, the rest use the predictor
    localparam t_stim_row DIR_TBL [0:24] = '{
        '{ACT_READ,   8'h00,     7'd0,   8'd0,   1'b1, ZERO_RES}, // read after reset
        '{ACT_TAKE,   8'h00,     7'd0,   8'd128, 1'b1, ZERO_RES}, // take, nothing waiting
        '{ACT_UNUSED, CH_DOLLAR, 7'd0,   8'd0,   1'b1, ZERO_RES}, // unused code is a no-op
        '{ACT_RX,     8'h41,     7'd0,   8'd0,   1'b1, ZERO_RES}, // outside a line
        '{ACT_RX,     CH_LF,     7'd0,   8'd0,   1'b1, ZERO_RES}, // line end outside a line
        '{ACT_RX,     CH_DOLLAR, 7'h7F,  8'd128, 1'b0, ZERO_RES},
        '{ACT_RX,     8'h47,     7'd0,   8'd0,   1'b0, ZERO_RES},
        '{ACT_RX,     CH_CR,     7'd0,   8'd0,   1'b0, ZERO_RES},
        '{ACT_RX,     8'hFF,     7'd0,   8'd0,   1'b0, ZERO_RES},
        '{ACT_RX,     8'h00,     7'd0,   8'd0,   1'b0, ZERO_RES},
        '{ACT_RX,     CH_DOLLAR, 7'd0,   8'd0,   1'b0, ZERO_RES}, // restart mid-line
        '{ACT_RX,     8'h50,     7'd0,   8'd0,   1'b0, ZERO_RES},
        '{ACT_RX,     8'h80,     7'd0,   8'd0,   1'b0, ZERO_RES},
        '{ACT_RX,     CH_LF,     7'd0,   8'd0,   1'b0, ZERO_RES},
        '{ACT_READ,   8'h00,     7'd0,   8'd0,   1'b0, ZERO_RES},
        '{ACT_READ,   8'hFF,     7'd2,   8'd0,   1'b0, ZERO_RES},
        '{ACT_READ,   8'h00,     7'd3,   8'd0,   1'b0, ZERO_RES}, // one past the length
        '{ACT_READ,   8'h00,     7'h7F,  8'd128, 1'b0, ZERO_RES},
        '{ACT_RX,     CH_DOLLAR, 7'd0,   8'd0,   1'b0, ZERO_RES},
        '{ACT_RX,     8'h5A,     7'd0,   8'd0,   1'b0, ZERO_RES},
        '{ACT_RX,     CH_LF,     7'd0,   8'd0,   1'b0, ZERO_RES}, // dropped, line waits
        '{ACT_TAKE,   8'h00,     7'd0,   8'd0,   1'b1, KEPT_RES}, // size zero keeps line
        '{ACT_TAKE,   8'h00,     7'd0,   8'd2,   1'b0, ZERO_RES},
        '{ACT_READ,   8'h00,     7'd0,   8'd0,   1'b1, ZERO_RES}, // line gone after take
        '{ACT_TAKE,   8'h00,     7'd0,   8'd128, 1'b1, ZERO_RES}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // expectation override that travels with the request on the bus
    logic         cur_typed = 1'b0;
    t_line_result cur_want = '0;

    int sender_idle = 0;
    int recv_stall = 0;
    int err_cnt = 0;
    int req_count = 0;
    int cycle_cnt = 0;

    t_line_result line_result_q[$];

    // predictor state
    logic [7:0] asm_buf [LINE_SIZE];
    logic [7:0] rdy_buf [LINE_SIZE];
    int         asm_len = 0;
    int         rdy_len = 0;
    bit         rdy_flag = 1'b0;
    bit         in_line = 1'b0;
    bit         ovf = 1'b0;

    int lines_framed = 0;
    int lines_lost = 0;
    int lines_overflowed = 0;
    int takes_ok = 0;
    int reads_hit = 0;

    nmea_line_framer_top #(
        .LINE_SIZE(LINE_SIZE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_line_result frame_line_step(input logic [1:0] act,
                                                     input logic [7:0] rx,
                                                     input logic [6:0] idx,
                                                     input logic [7:0] size);
        t_line_result res;
        int           sz;
        res = '0;
        case (act)
            ACT_RX: begin
                if (rx == CH_DOLLAR) begin
                    in_line    = 1'b1;
                    ovf        = 1'b0;
                    asm_buf[0] = rx;
                    asm_len    = 1;
                end else if (in_line) begin
                    if (rx == CH_LF) begin
                        if (ovf) begin
                            lines_overflowed++;
                        end else if (rdy_flag) begin
                            lines_lost++;
                        end else if (asm_len > 0) begin
                            for (int i = 0; i < asm_len; i++) rdy_buf[i] = asm_buf[i];
                            rdy_len  = asm_len;
                            rdy_flag = 1'b1;
                            lines_framed++;
                        end
                        in_line = 1'b0;
                        ovf     = 1'b0;
                        asm_len = 0;
                    end else if (rx != CH_CR) begin
                        if (asm_len < LINE_SIZE - 1) begin
                            asm_buf[asm_len] = rx;
                            asm_len++;
                        end else begin
                            ovf = 1'b1;
                        end
                    end
                end
                res.copy_length = 7'(rdy_len);
            end
            ACT_READ: begin
                if (int'(idx) < rdy_len) begin
                    res.ok        = 1'b1;
                    res.data_byte = rdy_buf[idx];
                    reads_hit++;
                end
                res.copy_length = 7'(rdy_len);
            end
            ACT_TAKE: begin
                sz = (int'(size) > LINE_SIZE) ? LINE_SIZE : int'(size);
                if (sz != 0 && rdy_flag) begin
                    res.copy_length = 7'((rdy_len >= sz) ? sz - 1 : rdy_len);
                    res.ok          = 1'b1;
                    rdy_flag        = 1'b0;
                    rdy_len         = 0;
                    takes_ok++;
                end
            end
            default: begin
                res.copy_length = 7'(rdy_len);
            end
        endcase
        res.line_waiting = rdy_flag;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < 40)
            $display("tb_top: mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    // request acceptance feeds the predictor; result acceptance is checked
    always @(posedge i_clk) begin
        t_line_result pred;
        t_line_result got;
        t_line_result want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                pred = frame_line_step(s_tuser, s_tdata[7:0], s_tdata[14:8], s_tdata[22:15]);
                line_result_q.push_back(cur_typed ? cur_want : pred);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[16:0];
                if (line_result_q.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata), 0);
                end else begin
                    want = line_result_q.pop_front();
                    if (got.ok != want.ok)
                        report_mismatch("ok", got.ok, want.ok);
                    if (got.data_byte != want.data_byte)
                        report_mismatch("data_byte", got.data_byte, want.data_byte);
                    if (got.copy_length != want.copy_length)
                        report_mismatch("copy_length", got.copy_length, want.copy_length);
                    if (got.line_waiting != want.line_waiting)
                        report_mismatch("line_waiting", got.line_waiting, want.line_waiting);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("tb_top: timeout after %0d cycles", cycle_cnt);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_req(input logic [1:0] act, input logic [7:0] rx,
                            input logic [6:0] idx, input logic [7:0] size,
                            input logic typed, input t_line_result want);
        while (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= act;
        s_tdata   <= {1'b0, size, idx, rx};
        cur_typed <= typed;
        cur_want  <= want;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_req(ACT_RX, b, 7'($urandom_range(127)), 8'($urandom_range(128)), 1'b0, ZERO_RES);
        req_count++;
    endtask

    task automatic send_take(input logic [7:0] size);
        send_req(ACT_TAKE, 8'($urandom_range(255)), 7'($urandom_range(127)), size,
                 1'b0, ZERO_RES);
        req_count++;
    endtask

    task automatic send_line(input int body_len);
        logic [7:0] b;
        send_rx(CH_DOLLAR);
        for (int i = 0; i < body_len; i++) begin
            b = 8'($urandom_range(255));
            if (b == CH_DOLLAR || b == CH_LF || b == CH_CR) b ^= 8'h40;
            send_rx(b);
        end
        send_rx(CH_LF);
    endtask

    task automatic consumer_op();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            send_req(ACT_READ, 8'($urandom_range(255)),
                     7'(($urandom_range(99) < 75) ? $urandom_range(24) : $urandom_range(127)),
                     8'($urandom_range(128)), 1'b0, ZERO_RES);
            req_count++;
        end else begin
            r = $urandom_range(99);
            if (r < 10)      send_take(8'd0);
            else if (r < 20) send_take(8'd128);
            else if (r < 30) send_take(8'($urandom_range(100, 127)));
            else             send_take(8'($urandom_range(1, 30)));
        end
    endtask

    // random sentence, with consumer requests mixed into the middle
    task automatic gen_sentence();
        int         body_len;
        int         tail;
        logic [1:0] act;
        logic [7:0] b;
        body_len = ($urandom_range(99) < 5) ? $urandom_range(120, 135) : $urandom_range(24);
        send_rx(CH_DOLLAR);
        for (int i = 0; i < body_len; i++) begin
            if ($urandom_range(99) < 4) consumer_op();
            if ($urandom_range(99) < 5) send_rx(CH_CR);
            b = 8'($urandom_range(255));
            if (b == CH_DOLLAR || b == CH_LF || b == CH_CR) b ^= 8'h40;
            send_rx(b);
        end
        tail = $urandom_range(99);
        if (tail < 86) begin
            send_rx(CH_LF);
        end else if (tail < 93) begin
            act = 2'($urandom_range(3));
            send_req(act, 8'($urandom_range(255)), 7'($urandom_range(127)),
                     8'($urandom_range(128)), 1'b0, ZERO_RES);
            req_count++;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (line_result_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int idle_plan [5];
        int stall_plan [5];
        int r;
        logic [1:0] act;
        idle_plan  = '{0, 59, 0, 37, 0};
        stall_plan = '{0, 0, 59, 37, 0};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TBL[i])
            send_req(DIR_TBL[i].act, DIR_TBL[i].rx, DIR_TBL[i].idx, DIR_TBL[i].size,
                     DIR_TBL[i].typed, DIR_TBL[i].want);

        // longest storable line, a full-size take, then an overflowing line
        send_line(LINE_SIZE - 2);
        send_take(8'd128);
        send_line(LINE_SIZE - 1);
        send_take(8'd128);

        req_count = 0;
        for (int ph = 0; ph < 5; ph++) begin
            // hold off the sender until the block has emptied out
            drain_results();
            sender_idle = idle_plan[ph];
            recv_stall  = stall_plan[ph];
            while (req_count < (ph + 1) * 230) begin
                r = $urandom_range(99);
                if (r < 75) begin
                    gen_sentence();
                    repeat ($urandom_range(3)) consumer_op();
                    if ($urandom_range(99) < 70) consumer_op();
                end else if (r < 90) begin
                    consumer_op();
                end else begin
                    act = 2'($urandom_range(3));
                    send_req(act, 8'($urandom_range(255)), 7'($urandom_range(127)),
                             8'($urandom_range(128)), 1'b0, ZERO_RES);
                    req_count++;
                end
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("tb_top: %0d random requests over 5 idle/stall phases after %0d directed",
                 req_count, $size(DIR_TBL));
        $display("tb_top: lines framed %0d, lost %0d, overflowed %0d, takes %0d, reads %0d",
                 lines_framed, lines_lost, lines_overflowed, takes_ok, reads_hit);
        if (err_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
